[hdl/tftp_wbr_pkg.sv]
// Shared types and constants for the TFTP write block receiver.
// No dependencies; every other file in hdl imports this package.
package tftp_wbr_pkg;

   // event codes on the request channel
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PACKET  = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // TFTP opcodes of interest
   localparam logic [15:0] TFTP_DATA = 16'd3;
   localparam logic [15:0] TFTP_ERR  = 16'd5;

   // TFTP error codes sent
   localparam logic [15:0] ERR_CODE_UNDEF       = 16'd0;
   localparam logic [15:0] ERR_CODE_UNKNOWN_TID = 16'd5;

   localparam logic [1:0] SEND_NONE  = 2'd0;
   localparam logic [1:0] SEND_ACK   = 2'd1;
   localparam logic [1:0] SEND_ERROR = 2'd2;

   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_RECEIVING   = 3'd1;
   localparam logic [2:0] ST_DONE        = 3'd2;
   localparam logic [2:0] ST_ABORT_PEER  = 3'd3;
   localparam logic [2:0] ST_ABORT_RETRY = 3'd4;

   localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;
   localparam logic [9:0] HEADER_BYTES      = 10'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] src_port;
      logic [15:0] pkt_opcode;
      logic [15:0] pkt_block;
      logic [9:0]  pkt_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic        to_stranger;
      logic [15:0] block_or_code;
      logic        commit_payload;
      logic [9:0]  payload_len;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // one decision from the front; stranger entries expand to ERROR 5 then rsp
   typedef struct packed {
      logic    stranger;
      rsp_type rsp;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[hdl/tftp_write_block_receiver.sv]
// TFTP write block receiver: stop-and-wait server side decision engine.
// An accepted event is written into the queue, then loaded into the output register.
// Throughput: one event per cycle; a stranger-port packet puts two result items
// through the output register (ERROR then ACK). Events stall only on a full queue.
// Reset (synchronous): idle, block 0, no client port, retries 0, max 10.
// Depends on tftp_wbr_pkg, tftp_wbr_front, tftp_wbr_fifo, tftp_wbr_back.
module tftp_write_block_receiver #(
   parameter int PACKET_BYTES = 516,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tftp_wbr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tftp_wbr_pkg::rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data
);
   import tftp_wbr_pkg::*;

   logic         push;
   logic         pop;
   entry_type    push_data;
   entry_type    head;
   q_status_type q_status;

   tftp_wbr_front #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   tftp_wbr_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   tftp_wbr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

[hdl/tftp_wbr_front.sv]
// Front end: accepts events, holds the session state and classifies each
// event into a queue entry. Depends on tftp_wbr_pkg.
module tftp_wbr_front #(
   parameter int PACKET_BYTES = 516
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tftp_wbr_pkg::req_type    req_data,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  tftp_wbr_pkg::q_status_type q_status,
   output logic                     push,
   output tftp_wbr_pkg::entry_type  push_data
);
   import tftp_wbr_pkg::*;

   localparam int LW = ($clog2(PACKET_BYTES + 1) > 10) ? $clog2(PACKET_BYTES + 1) : 10;
   localparam logic [LW-1:0] PKT_BYTES_C = LW'(PACKET_BYTES);
   localparam logic [LW-1:0] LEN_MIN_C   = LW'(4);

   logic        phase_ff, phase_in;
   logic [15:0] exp_ff, exp_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  retry_ff, retry_in;
   logic [7:0]  max_ff;

   logic          accept;
   logic          retry_lt;
   logic [15:0]   exp_next;
   logic [LW-1:0] len_ext;
   logic          data_ok;
   logic          short_blk;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign retry_lt  = retry_ff < max_ff;
   assign exp_next  = exp_ff + 16'd1;
   assign len_ext   = LW'(req_data.pkt_len);
   assign data_ok   = (req_data.pkt_opcode == TFTP_DATA) &&
                      (len_ext inside {[LEN_MIN_C:PKT_BYTES_C]}) &&
                      (req_data.pkt_block == exp_next);
   assign short_blk = len_ext < PKT_BYTES_C;

   always_comb begin
      phase_in  = phase_ff;
      exp_in    = exp_ff;
      port_in   = port_ff;
      retry_in  = retry_ff;
      push      = 1'b0;
      push_data = '0;
      push_data.rsp.last = 1'b1;
      if (accept) begin
         case (req_data.op)
            OP_START: begin
               phase_in = 1'b1;
               exp_in   = '0;
               port_in  = '0;
               retry_in = '0;
               push     = 1'b1;
               push_data.rsp.send_kind = SEND_ACK;
               push_data.rsp.status    = ST_RECEIVING;
            end
            OP_TIMEOUT: begin
               if (phase_ff) begin
                  push = 1'b1;
                  if (retry_lt) begin
                     retry_in = retry_ff + 8'd1;
                     push_data.rsp.send_kind     = SEND_ACK;
                     push_data.rsp.block_or_code = exp_ff;
                     push_data.rsp.status        = ST_RECEIVING;
                  end else begin
                     phase_in = 1'b0;
                     push_data.rsp.send_kind     = SEND_ERROR;
                     push_data.rsp.block_or_code = ERR_CODE_UNDEF;
                     push_data.rsp.status        = ST_ABORT_RETRY;
                  end
               end
            end
            OP_PACKET: begin
               if (phase_ff) begin
                  push = 1'b1;
                  if (port_ff == '0) begin
                     port_in = req_data.src_port;
                  end
                  if (port_ff != '0 && port_ff != req_data.src_port) begin
                     // stranger: back end adds the ERROR 5 ahead of this ACK
                     push_data.stranger          = 1'b1;
                     push_data.rsp.send_kind     = SEND_ACK;
                     push_data.rsp.block_or_code = exp_ff;
                     push_data.rsp.status        = ST_RECEIVING;
                  end else if (data_ok) begin
                     exp_in   = req_data.pkt_block;
                     retry_in = '0;
                     if (short_blk) begin
                        phase_in = 1'b0;
                     end
                     push_data.rsp.send_kind      = SEND_ACK;
                     push_data.rsp.block_or_code  = req_data.pkt_block;
                     push_data.rsp.commit_payload = 1'b1;
                     push_data.rsp.payload_len    = req_data.pkt_len - HEADER_BYTES;
                     push_data.rsp.status         = short_blk ? ST_DONE : ST_RECEIVING;
                  end else if (req_data.pkt_opcode == TFTP_ERR) begin
                     phase_in = 1'b0;
                     push_data.rsp.send_kind = SEND_NONE;
                     push_data.rsp.status    = ST_ABORT_PEER;
                  end else begin
                     if (retry_lt) begin
                        retry_in = retry_ff + 8'd1;
                     end
                     push_data.rsp.send_kind     = SEND_ACK;
                     push_data.rsp.block_or_code = exp_ff;
                     push_data.rsp.status        = ST_RECEIVING;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         exp_ff   <= '0;
         port_ff  <= '0;
         retry_ff <= '0;
         max_ff   <= MAX_RETRIES_RESET;
      end else begin
         phase_ff <= phase_in;
         exp_ff   <= exp_in;
         port_ff  <= port_in;
         retry_ff <= retry_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

endmodule

[hdl/tftp_wbr_fifo.sv]
// Small register queue between front and back ends.
// Depends on tftp_wbr_pkg.
module tftp_wbr_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tftp_wbr_pkg::entry_type    push_data,
   input  logic                       pop,
   output tftp_wbr_pkg::entry_type    head,
   output tftp_wbr_pkg::q_status_type q_status
);
   import tftp_wbr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   entry_type     mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == DEPTH_C;
   assign q_status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/tftp_wbr_back.sv]
// Back end: expands queue entries into result items and holds the
// output register. Depends on tftp_wbr_pkg.
module tftp_wbr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tftp_wbr_pkg::entry_type    head,
   input  tftp_wbr_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tftp_wbr_pkg::rsp_type      rsp_data
);
   import tftp_wbr_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    second_ff, second_in;
   logic    load;
   rsp_type err_rsp;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      err_rsp               = '0;
      err_rsp.send_kind     = SEND_ERROR;
      err_rsp.to_stranger   = 1'b1;
      err_rsp.block_or_code = ERR_CODE_UNKNOWN_TID;
      err_rsp.status        = ST_RECEIVING;
      err_rsp.last          = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (load) begin
         if (q_status.empty) begin
            rsp_valid_in = 1'b0;
         end else if (head.stranger && !second_ff) begin
            // head stays queued until its ACK half goes out
            rsp_valid_in = 1'b1;
            rsp_data_in  = err_rsp;
            second_in    = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = head.rsp;
            second_in    = 1'b0;
            pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
